/* rtl/isfk_pkg.sv */
// Shared types and constants for the inverse-square force kernel.
// Depends on nothing; used by isfk_pipe and inverse_square_force_kernel_unit.
`default_nettype none

package isfk_pkg;

	// configuration port
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ATTR_X   = 3'd0,
		REG_ATTR_Y   = 3'd1,
		REG_ATTR_Z   = 3'd2,
		REG_STRENGTH = 3'd3,
		REG_MIN_DIST = 3'd4
	} reg_idx_t;

	// reset value of min_distance (1.0 in Q16.16)
	localparam logic [31:0] MIN_DIST_RST = 32'h0001_0000;

	// cycles from an accepted item to its result strobe
	localparam int PIPE_LAT = 70;

	typedef struct packed {
		logic signed [31:0] particle_x;
		logic signed [31:0] particle_y;
		logic signed [31:0] particle_z;
		logic        [31:0] particle_mass;
		logic               particle_free;
		logic signed [31:0] force_in_x;
		logic signed [31:0] force_in_y;
		logic signed [31:0] force_in_z;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] force_out_x;
		logic signed [31:0] force_out_y;
		logic signed [31:0] force_out_z;
	} out_item_t;

	typedef struct packed {
		logic signed [31:0] attractor_x;
		logic signed [31:0] attractor_y;
		logic signed [31:0] attractor_z;
		logic signed [31:0] strength;
		logic        [31:0] min_distance;
	} cfg_t;

	// per-item side data that rides along the long arithmetic stages
	typedef struct packed {
		logic             free;
		logic [2:0]       en;   // direction component is negative
		logic [2:0][31:0] ea;   // direction component magnitude
		logic [2:0][31:0] fin;  // incoming force accumulator
	} carry_t;

endpackage

`default_nettype wire

/* rtl/isfk_pipe.sv */
// Datapath pipeline of the force kernel: offsets, squares, magnitude divide,
// length square root, per-axis divide and saturating add. Uses isfk_pkg.
`default_nettype none

module isfk_pipe #(
	parameter int FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  isfk_pkg::in_item_t  in_item,
	input  isfk_pkg::cfg_t      cfg,
	output logic                out_valid,
	output isfk_pkg::out_item_t out_item
);
	import isfk_pkg::*;

	localparam int D2_W  = 67 - FRAC_BITS;   // clamped squared distance
	localparam int MM_W  = 64 - FRAC_BITS;   // mass squared
	localparam int MM_LO = MM_W / 2;
	localparam int MM_HI = MM_W - MM_LO;
	localparam int PLO_W = 32 + MM_LO;
	localparam int PHI_W = 32 + MM_HI;
	localparam int PW    = 32 + MM_W;        // strength * mass term
	localparam int RW    = D2_W + 31;        // magnitude divide remainder
	localparam int NC    = 32;               // root steps (magnitude divide rides along)
	localparam int ND    = 31;               // per-axis quotient bits

	// ---------------- valid chain ----------------
	logic          v_s1, v_s2, v_s3, v_s4, v_s5, v_s7, v_s9;
	logic [NC-1:0] v_s6;
	logic [ND-1:0] v_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= '0;
			v_s7 <= 1'b0;
			v_s8 <= '0;
			v_s9 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= {v_s6[NC-2:0], v_s5};
			v_s7 <= v_s6[NC-1];
			v_s8 <= {v_s8[ND-2:0], v_s7};
			v_s9 <= v_s8[ND-1];
		end
	end

	// ---------------- stage 1: offsets ----------------
	logic signed [32:0] d_s1 [3];
	logic               free_s1;
	logic [31:0]        mass_s1;
	logic [2:0][31:0]   fin_s1;

	always_ff @(posedge clk) begin
		d_s1[0] <= 33'(in_item.particle_x) - 33'(cfg.attractor_x);
		d_s1[1] <= 33'(in_item.particle_y) - 33'(cfg.attractor_y);
		d_s1[2] <= 33'(in_item.particle_z) - 33'(cfg.attractor_z);
		free_s1 <= in_item.particle_free;
		mass_s1 <= in_item.particle_mass;
		fin_s1  <= {in_item.force_in_z, in_item.force_in_y, in_item.force_in_x};
	end

	// ---------------- stage 2: squares, direction prescale ----------------
	logic [31:0] ad [3];
	logic        big;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			ad[k] = d_s1[k][32] ? 32'(-d_s1[k]) : d_s1[k][31:0];
		end
		big = ad[0][31] | ad[1][31] | ad[2][31];
	end

	logic [63:0]        sq_s2 [3];
	logic signed [31:0] e_s2 [3];
	logic [63:0]        msq_s2, mmsq_s2;
	logic               free_s2;
	logic [2:0][31:0]   fin_s2;

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			sq_s2[k] <= 64'(ad[k]) * 64'(ad[k]);
			// halve every axis when one offset overflows 32 bits
			e_s2[k]  <= big ? d_s1[k][32:1] : d_s1[k][31:0];
		end
		msq_s2  <= 64'(cfg.min_distance) * 64'(cfg.min_distance);
		mmsq_s2 <= 64'(mass_s1) * 64'(mass_s1);
		free_s2 <= free_s1;
		fin_s2  <= fin_s1;
	end

	// ---------------- stage 3: distance sum and clamp ----------------
	logic [D2_W-1:0] d2sum, m2, d2c;
	logic [31:0]     ea [3];

	always_comb begin
		d2sum = D2_W'(sq_s2[0] >> FRAC_BITS) + D2_W'(sq_s2[1] >> FRAC_BITS)
		      + D2_W'(sq_s2[2] >> FRAC_BITS);
		m2    = D2_W'(msq_s2 >> FRAC_BITS);
		d2c   = (d2sum < m2) ? m2 : d2sum;
		if (d2c == '0) begin
			d2c = D2_W'(1);
		end
		for (int k = 0; k < 3; k++) begin
			ea[k] = e_s2[k][31] ? 32'(-e_s2[k]) : 32'(e_s2[k]);
		end
	end

	logic [D2_W-1:0] d2_s3;
	logic [MM_W-1:0] mm_s3;
	logic [63:0]     e2_s3 [3];
	carry_t          cr_s3;

	always_ff @(posedge clk) begin
		d2_s3 <= d2c;
		mm_s3 <= MM_W'(mmsq_s2 >> FRAC_BITS);
		for (int k = 0; k < 3; k++) begin
			e2_s3[k]    <= 64'(ea[k]) * 64'(ea[k]);
			cr_s3.ea[k] <= ea[k];
			cr_s3.en[k] <= e_s2[k][31];
		end
		cr_s3.free <= free_s2;
		cr_s3.fin  <= fin_s2;
	end

	// ---------------- stage 4: strength * mass partial products ----------------
	logic [31:0] sabs;
	assign sabs = cfg.strength[31] ? 32'(-cfg.strength) : cfg.strength;

	logic [PLO_W-1:0] pplo_s4;
	logic [PHI_W-1:0] pphi_s4;
	logic [63:0]      vsum_s4;
	logic [D2_W-1:0]  d2_s4;
	carry_t           cr_s4;

	always_ff @(posedge clk) begin
		pplo_s4 <= PLO_W'(sabs) * PLO_W'(mm_s3[MM_LO-1:0]);
		pphi_s4 <= PHI_W'(sabs) * PHI_W'(mm_s3[MM_W-1:MM_LO]);
		vsum_s4 <= e2_s3[0] + e2_s3[1] + e2_s3[2];
		d2_s4   <= d2_s3;
		cr_s4   <= cr_s3;
	end

	// ---------------- stage 5: product assembly ----------------
	logic [PW-1:0]   p_s5;
	logic [63:0]     vsum_s5;
	logic [D2_W-1:0] d2_s5;
	carry_t          cr_s5;

	always_ff @(posedge clk) begin
		p_s5    <= PW'(pplo_s4) + (PW'(pphi_s4) << MM_LO);
		vsum_s5 <= vsum_s4;
		d2_s5   <= d2_s4;
		cr_s5   <= cr_s4;
	end

	// ---------------- stage group 6: root and magnitude divide ----------------
	// step k: root trial bit 4^(31-k); divide quotient bit 31-k (k>0),
	// k=0 checks the quotient against the 31-bit cap
	logic [63:0]     rx_s6  [NC];
	logic [63:0]     rr_s6  [NC];
	logic [RW-1:0]   rem_s6 [NC];
	logic [30:0]     q_s6   [NC];
	logic            sat_s6 [NC];
	logic [D2_W-1:0] d2_s6  [NC];
	carry_t          cr_s6  [NC];

	always_ff @(posedge clk) begin
		if (vsum_s5 >= (64'd1 << 62)) begin
			rx_s6[0] <= vsum_s5 - (64'd1 << 62);
			rr_s6[0] <= 64'd1 << 62;
		end else begin
			rx_s6[0] <= vsum_s5;
			rr_s6[0] <= '0;
		end
		rem_s6[0] <= RW'(p_s5);
		sat_s6[0] <= (p_s5 >> 31) >= PW'(d2_s5);
		q_s6[0]   <= '0;
		d2_s6[0]  <= d2_s5;
		cr_s6[0]  <= cr_s5;
		for (int k = 1; k < NC; k++) begin
			if (rx_s6[k-1] >= rr_s6[k-1] + (64'd1 << (62 - 2 * k))) begin
				rx_s6[k] <= rx_s6[k-1] - (rr_s6[k-1] + (64'd1 << (62 - 2 * k)));
				rr_s6[k] <= (rr_s6[k-1] >> 1) + (64'd1 << (62 - 2 * k));
			end else begin
				rx_s6[k] <= rx_s6[k-1];
				rr_s6[k] <= rr_s6[k-1] >> 1;
			end
			if (rem_s6[k-1] >= (RW'(d2_s6[k-1]) << (31 - k))) begin
				rem_s6[k] <= rem_s6[k-1] - (RW'(d2_s6[k-1]) << (31 - k));
				q_s6[k]   <= q_s6[k-1] | (31'd1 << (31 - k));
			end else begin
				rem_s6[k] <= rem_s6[k-1];
				q_s6[k]   <= q_s6[k-1];
			end
			sat_s6[k] <= sat_s6[k-1];
			d2_s6[k]  <= d2_s6[k-1];
			cr_s6[k]  <= cr_s6[k-1];
		end
	end

	// ---------------- stage 7: magnitude times direction ----------------
	logic [30:0] mag;
	assign mag = sat_s6[NC-1] ? '1 : q_s6[NC-1];

	logic [2:0][62:0] num_s7;
	logic [31:0]      len_s7;
	carry_t           cr_s7;

	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			num_s7[a] <= 63'(mag) * 63'(cr_s6[NC-1].ea[a]);
		end
		len_s7 <= rr_s6[NC-1][31:0];
		cr_s7  <= cr_s6[NC-1];
	end

	// ---------------- stage group 8: per-axis divide by length ----------------
	logic [2:0][62:0] rem2_s8 [ND];
	logic [2:0][30:0] q2_s8   [ND];
	logic [31:0]      len_s8  [ND];
	carry_t           cr_s8   [ND];

	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			if (num_s7[a] >= (63'(len_s7) << (ND - 1))) begin
				rem2_s8[0][a] <= num_s7[a] - (63'(len_s7) << (ND - 1));
				q2_s8[0][a]   <= 31'd1 << (ND - 1);
			end else begin
				rem2_s8[0][a] <= num_s7[a];
				q2_s8[0][a]   <= '0;
			end
		end
		len_s8[0] <= len_s7;
		cr_s8[0]  <= cr_s7;
		for (int j = 1; j < ND; j++) begin
			for (int a = 0; a < 3; a++) begin
				if (rem2_s8[j-1][a] >= (63'(len_s8[j-1]) << (ND - 1 - j))) begin
					rem2_s8[j][a] <= rem2_s8[j-1][a] - (63'(len_s8[j-1]) << (ND - 1 - j));
					q2_s8[j][a]   <= q2_s8[j-1][a] | (31'd1 << (ND - 1 - j));
				end else begin
					rem2_s8[j][a] <= rem2_s8[j-1][a];
					q2_s8[j][a]   <= q2_s8[j-1][a];
				end
			end
			len_s8[j] <= len_s8[j-1];
			cr_s8[j]  <= cr_s8[j-1];
		end
	end

	// ---------------- stage 9: signed component and saturating add ----------------
	logic               zero_f;
	logic signed [32:0] comp [3];
	logic signed [33:0] acc  [3];
	logic [31:0]        fo   [3];

	always_comb begin
		zero_f = !cr_s8[ND-1].free || (len_s8[ND-1] == '0);
		for (int a = 0; a < 3; a++) begin
			if (zero_f) begin
				comp[a] = '0;
			end else if (cfg.strength[31] ^ cr_s8[ND-1].en[a]) begin
				comp[a] = -$signed({2'b00, q2_s8[ND-1][a]});
			end else begin
				comp[a] = $signed({2'b00, q2_s8[ND-1][a]});
			end
			acc[a] = 34'($signed(cr_s8[ND-1].fin[a])) + 34'(comp[a]);
			if (acc[a] > 34'sd2147483647) begin
				fo[a] = 32'h7FFF_FFFF;
			end else if (acc[a] < -34'sd2147483648) begin
				fo[a] = 32'h8000_0000;
			end else begin
				fo[a] = acc[a][31:0];
			end
		end
	end

	out_item_t res_s9;

	always_ff @(posedge clk) begin
		res_s9.force_out_x <= fo[0];
		res_s9.force_out_y <= fo[1];
		res_s9.force_out_z <= fo[2];
	end

	assign out_valid = v_s9;
	assign out_item  = res_s9;

endmodule

`default_nettype wire

/* rtl/inverse_square_force_kernel_unit.sv */
// Each accepted start yields a done strobe carrying its result.
// Throughput: one item per cycle; busy stays low, the pipeline never stalls.
// The long stages are the 32-step length root (carrying the magnitude divide)
// and the 31-step per-axis divide, one quotient bit per stage.
// Reset (arst_n low, async): pipeline emptied, point and strength zero,
// min_distance 1.0. Top level: config registers and the isfk_pipe datapath.
`default_nettype none

module inverse_square_force_kernel_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  isfk_pkg::in_item_t                  particle,
	output logic                                done,
	output isfk_pkg::out_item_t                 result,
	input  logic                                cfg_we,
	input  logic [isfk_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [isfk_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import isfk_pkg::*;

	// configuration registers
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.attractor_x  <= '0;
			cfg_q.attractor_y  <= '0;
			cfg_q.attractor_z  <= '0;
			cfg_q.strength     <= '0;
			cfg_q.min_distance <= MIN_DIST_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_ATTR_X:   cfg_q.attractor_x  <= cfg_data;
				REG_ATTR_Y:   cfg_q.attractor_y  <= cfg_data;
				REG_ATTR_Z:   cfg_q.attractor_z  <= cfg_data;
				REG_STRENGTH: cfg_q.strength     <= cfg_data;
				REG_MIN_DIST: cfg_q.min_distance <= cfg_data;
				default: ;
			endcase
		end
	end

	// fully pipelined: always ready for the next item
	assign busy = 1'b0;

	logic accept;
	assign accept = start & ~busy;

	isfk_pipe #(
		.FRAC_BITS(FRAC_BITS)
	) u_pipe (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.in_item  (particle),
		.cfg      (cfg_q),
		.out_valid(done),
		.out_item (result)
	);

`ifndef SYNTHESIS
	// every result traces back to an item accepted a fixed latency earlier
	a_done_from_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, PIPE_LAT))
		else $error("done without a matching item");

	// a pinned particle passes its accumulator through
	a_pinned_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(!particle.particle_free, PIPE_LAT)) |->
		(result.force_out_x == $past(particle.force_in_x, PIPE_LAT) &&
		 result.force_out_y == $past(particle.force_in_y, PIPE_LAT) &&
		 result.force_out_z == $past(particle.force_in_z, PIPE_LAT)))
		else $error("pinned particle force changed");

	// a particle sitting on the point gets no force
	a_zero_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(particle.particle_x == cfg_q.attractor_x &&
		               particle.particle_y == cfg_q.attractor_y &&
		               particle.particle_z == cfg_q.attractor_z, PIPE_LAT)) |->
		(result.force_out_x == $past(particle.force_in_x, PIPE_LAT) &&
		 result.force_out_y == $past(particle.force_in_y, PIPE_LAT) &&
		 result.force_out_z == $past(particle.force_in_z, PIPE_LAT)))
		else $error("zero offset produced a force");
`endif

endmodule

`default_nettype wire
